// ----- hw/rtl/spq_pkg.sv -----
// Shared types and constants for the strict-priority two-queue scheduler.
// No dependencies; the scheduler top level imports this package.

package spq_pkg;

    localparam int ID_WIDTH    = 16;
    localparam int TIME_WIDTH  = 32;
    localparam int CNT_WIDTH   = 32;
    localparam int TOT_WIDTH   = 48;
    localparam int LIMIT_WIDTH = 5;

    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 5'd16;

    // Kind codes of an input item; the high bit alone marks a service tick.
    localparam logic [1:0] KIND_HIGH = 2'd0;
    localparam logic [1:0] KIND_LOW  = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    typedef enum logic [2:0] {
        OUT_ACCEPTED    = 3'd0,
        OUT_REFUSED     = 3'd1,
        OUT_HIGH_SERVED = 3'd2,
        OUT_LOW_SERVED  = 3'd3,
        OUT_IDLE        = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_READ = 2'd2
    } sched_state_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [ID_WIDTH-1:0]   plane_id;
        logic [TIME_WIDTH-1:0] plane_start_time;
        logic [TIME_WIDTH-1:0] current_time;
    } sched_in_t;

    typedef struct packed {
        outcome_t              outcome;
        logic [ID_WIDTH-1:0]   served_id;
        logic [TIME_WIDTH-1:0] wait_time;
        logic [CNT_WIDTH-1:0]  high_requests;
        logic [CNT_WIDTH-1:0]  high_refused;
        logic [CNT_WIDTH-1:0]  high_finished;
        logic [TOT_WIDTH-1:0]  high_wait_total;
        logic [CNT_WIDTH-1:0]  low_requests;
        logic [CNT_WIDTH-1:0]  low_refused;
        logic [CNT_WIDTH-1:0]  low_finished;
        logic [TOT_WIDTH-1:0]  low_wait_total;
        logic [CNT_WIDTH-1:0]  idle_total;
    } sched_out_t;

    typedef struct packed {
        logic [ID_WIDTH-1:0]   id;
        logic [TIME_WIDTH-1:0] start_time;
    } queue_entry_t;

endpackage

// ----- hw/rtl/spq_queue_ram.sv -----
// Single-port-write, single-port-read queue memory with a registered read.
// Stand-alone; used twice by the scheduler top level, once per class.

module spq_queue_ram #(
    parameter int DEPTH = 16,
    parameter int ADDR_WIDTH = 4,
    parameter int DATA_WIDTH = 48
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_WIDTH-1:0] wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_WIDTH-1:0] rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/strict_priority_two_queue_scheduler_unit.sv -----
// Top level of the strict-priority two-queue scheduler with tail drop.
// Depends on spq_pkg and on spq_queue_ram, which holds each class's queue.
//
// Usage: items arrive on the s_ channel (valid/ready), each a high-priority
// request, a low-priority request or a service tick. Every item yields
// exactly one result on the m_ channel, carrying the outcome, the served id
// and wait time on a pop, and all statistics counters after the update.
// The queue limit is written on the cfg_ channel, which is always ready;
// write it only while no item is in flight.
// Sequence: a request is taken into the holding register, then executed
// and its result loaded into the output register. A tick that finds a
// queue non-empty first reads the head entry through the queue memory's
// registered read, then loads its result; one that finds both queues empty
// loads its idle result when executed. One item is in flight at a time.
// Reset: queues become empty, all counters clear and the limit returns to
// 16. The queue memories are not cleared; only entries written are read.
// Stall: one result is held in the output register; the next item is still
// taken into the holding register and waits there until the result is
// transferred.

module strict_priority_two_queue_scheduler_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  spq_pkg::sched_in_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output spq_pkg::sched_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [spq_pkg::LIMIT_WIDTH-1:0] cfg_data
);

    import spq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int LW = (CW > LIMIT_WIDTH) ? CW : LIMIT_WIDTH;
    localparam int EW = $bits(queue_entry_t);

    sched_state_t state_reg, state_next;
    sched_in_t    item_reg, item_next;
    logic [LIMIT_WIDTH-1:0] limit_reg, limit_next;

    logic [AW-1:0] high_head_reg, high_head_next, low_head_reg, low_head_next;
    logic [CW-1:0] high_count_reg, high_count_next, low_count_reg, low_count_next;
    logic          pop_low_reg, pop_low_next;

    logic [CNT_WIDTH-1:0] high_requests_reg, high_requests_next;
    logic [CNT_WIDTH-1:0] high_refused_reg, high_refused_next;
    logic [CNT_WIDTH-1:0] high_finished_reg, high_finished_next;
    logic [TOT_WIDTH-1:0] high_wait_reg, high_wait_next;
    logic [CNT_WIDTH-1:0] low_requests_reg, low_requests_next;
    logic [CNT_WIDTH-1:0] low_refused_reg, low_refused_next;
    logic [CNT_WIDTH-1:0] low_finished_reg, low_finished_next;
    logic [TOT_WIDTH-1:0] low_wait_reg, low_wait_next;
    logic [CNT_WIDTH-1:0] idle_total_reg, idle_total_next;

    sched_out_t out_reg, out_next;
    logic       out_valid_reg, out_valid_next;

    logic         out_free;
    logic         is_tick;
    logic         is_low;
    logic [AW-1:0] sel_head;
    logic [CW-1:0] sel_count;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail_addr;
    logic          push_ok;
    logic          any_pending;
    logic [AW-1:0] high_head_inc, low_head_inc;
    queue_entry_t  push_entry;
    queue_entry_t  pop_entry;
    logic [EW-1:0] high_rd_data, low_rd_data;
    logic [TIME_WIDTH-1:0] wait_val;
    logic          load_out;
    outcome_t      outcome_sel;
    logic [ID_WIDTH-1:0]   sid_sel;
    logic [TIME_WIDTH-1:0] wait_sel;
    logic high_wr_en, low_wr_en, high_rd_en, low_rd_en;

    spq_queue_ram #(
        .DEPTH      (QUEUE_DEPTH),
        .ADDR_WIDTH (AW),
        .DATA_WIDTH (EW)
    ) u_high_ram (
        .aclk    (aclk),
        .wr_en   (high_wr_en),
        .wr_addr (tail_addr),
        .wr_data (push_entry),
        .rd_en   (high_rd_en),
        .rd_addr (high_head_reg),
        .rd_data (high_rd_data)
    );

    spq_queue_ram #(
        .DEPTH      (QUEUE_DEPTH),
        .ADDR_WIDTH (AW),
        .DATA_WIDTH (EW)
    ) u_low_ram (
        .aclk    (aclk),
        .wr_en   (low_wr_en),
        .wr_addr (tail_addr),
        .wr_data (push_entry),
        .rd_en   (low_rd_en),
        .rd_addr (low_head_reg),
        .rd_data (low_rd_data)
    );

    assign out_free    = !out_valid_reg || m_ready;
    assign is_tick     = item_reg.kind[1];
    assign is_low      = item_reg.kind[0];
    assign any_pending = (high_count_reg != '0) || (low_count_reg != '0);

    assign sel_head  = is_low ? low_head_reg : high_head_reg;
    assign sel_count = is_low ? low_count_reg : high_count_reg;

    // The tail lies below twice the depth, so one compare and subtract wraps it.
    assign tail_sum  = SW'(sel_head) + SW'(sel_count);
    assign tail_addr = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
                                                      : AW'(tail_sum);

    // A limit above the depth acts as the depth.
    assign push_ok = (LW'(sel_count) < LW'(limit_reg)) && (sel_count < CW'(QUEUE_DEPTH));

    assign high_head_inc = (high_head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : high_head_reg + 1'b1;
    assign low_head_inc  = (low_head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : low_head_reg + 1'b1;

    assign push_entry.id         = item_reg.plane_id;
    assign push_entry.start_time = item_reg.plane_start_time;

    assign pop_entry = pop_low_reg ? queue_entry_t'(low_rd_data) : queue_entry_t'(high_rd_data);
    assign wait_val  = item_reg.current_time - pop_entry.start_time;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = (is_tick && any_pending) ? ST_READ : ST_IDLE;
                end
            end
            ST_READ: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        item_next          = item_reg;
        limit_next         = cfg_valid ? cfg_data : limit_reg;
        high_head_next     = high_head_reg;
        low_head_next      = low_head_reg;
        high_count_next    = high_count_reg;
        low_count_next     = low_count_reg;
        pop_low_next       = pop_low_reg;
        high_requests_next = high_requests_reg;
        high_refused_next  = high_refused_reg;
        high_finished_next = high_finished_reg;
        high_wait_next     = high_wait_reg;
        low_requests_next  = low_requests_reg;
        low_refused_next   = low_refused_reg;
        low_finished_next  = low_finished_reg;
        low_wait_next      = low_wait_reg;
        idle_total_next    = idle_total_reg;
        high_wr_en         = 1'b0;
        low_wr_en          = 1'b0;
        high_rd_en         = 1'b0;
        low_rd_en          = 1'b0;
        load_out           = 1'b0;
        outcome_sel        = OUT_ACCEPTED;
        sid_sel            = '0;
        wait_sel           = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    if (!is_tick) begin
                        load_out    = 1'b1;
                        outcome_sel = push_ok ? OUT_ACCEPTED : OUT_REFUSED;
                        if (is_low) begin
                            low_requests_next = low_requests_reg + 1'b1;
                            if (push_ok) begin
                                low_wr_en      = 1'b1;
                                low_count_next = low_count_reg + 1'b1;
                            end else begin
                                low_refused_next = low_refused_reg + 1'b1;
                            end
                        end else begin
                            high_requests_next = high_requests_reg + 1'b1;
                            if (push_ok) begin
                                high_wr_en      = 1'b1;
                                high_count_next = high_count_reg + 1'b1;
                            end else begin
                                high_refused_next = high_refused_reg + 1'b1;
                            end
                        end
                    end else if (high_count_reg != '0) begin
                        high_rd_en      = 1'b1;
                        high_head_next  = high_head_inc;
                        high_count_next = high_count_reg - 1'b1;
                        pop_low_next    = 1'b0;
                    end else if (low_count_reg != '0) begin
                        low_rd_en      = 1'b1;
                        low_head_next  = low_head_inc;
                        low_count_next = low_count_reg - 1'b1;
                        pop_low_next   = 1'b1;
                    end else begin
                        load_out        = 1'b1;
                        outcome_sel     = OUT_IDLE;
                        idle_total_next = idle_total_reg + 1'b1;
                    end
                end
            end
            ST_READ: begin
                // Head entry is now in the memory's read register.
                load_out = 1'b1;
                sid_sel  = pop_entry.id;
                wait_sel = wait_val;
                if (pop_low_reg) begin
                    outcome_sel       = OUT_LOW_SERVED;
                    low_finished_next = low_finished_reg + 1'b1;
                    low_wait_next     = low_wait_reg + TOT_WIDTH'(wait_val);
                end else begin
                    outcome_sel        = OUT_HIGH_SERVED;
                    high_finished_next = high_finished_reg + 1'b1;
                    high_wait_next     = high_wait_reg + TOT_WIDTH'(wait_val);
                end
            end
            default: begin
                load_out = 1'b0;
            end
        endcase

        out_next.outcome         = outcome_sel;
        out_next.served_id       = sid_sel;
        out_next.wait_time       = wait_sel;
        out_next.high_requests   = high_requests_next;
        out_next.high_refused    = high_refused_next;
        out_next.high_finished   = high_finished_next;
        out_next.high_wait_total = high_wait_next;
        out_next.low_requests    = low_requests_next;
        out_next.low_refused     = low_refused_next;
        out_next.low_finished    = low_finished_next;
        out_next.low_wait_total  = low_wait_next;
        out_next.idle_total      = idle_total_next;

        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            limit_reg         <= LIMIT_RESET;
            high_head_reg     <= '0;
            low_head_reg      <= '0;
            high_count_reg    <= '0;
            low_count_reg     <= '0;
            pop_low_reg       <= 1'b0;
            high_requests_reg <= '0;
            high_refused_reg  <= '0;
            high_finished_reg <= '0;
            high_wait_reg     <= '0;
            low_requests_reg  <= '0;
            low_refused_reg   <= '0;
            low_finished_reg  <= '0;
            low_wait_reg      <= '0;
            idle_total_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            state_reg         <= state_next;
            limit_reg         <= limit_next;
            high_head_reg     <= high_head_next;
            low_head_reg      <= low_head_next;
            high_count_reg    <= high_count_next;
            low_count_reg     <= low_count_next;
            pop_low_reg       <= pop_low_next;
            high_requests_reg <= high_requests_next;
            high_refused_reg  <= high_refused_next;
            high_finished_reg <= high_finished_next;
            high_wait_reg     <= high_wait_next;
            low_requests_reg  <= low_requests_next;
            low_refused_reg   <= low_refused_next;
            low_finished_reg  <= low_finished_next;
            low_wait_reg      <= low_wait_next;
            idle_total_reg    <= idle_total_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        if (load_out) begin
            out_reg <= out_next;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    // A queue never holds more entries than it has places.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (high_count_reg <= CW'(QUEUE_DEPTH)) && (low_count_reg <= CW'(QUEUE_DEPTH)))
        else $error("queue occupancy above depth");

    // A new result never overwrites one that has not been transferred.
    assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> out_free)
        else $error("result register overwritten");

    // The read cycle only follows a pop issued from the execute cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> ($past(state_reg) == ST_EXEC) && !out_valid_reg)
        else $error("read cycle without a pop");

    // A pop reduces the occupancy of exactly one queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (high_rd_en || low_rd_en) |-> !(high_rd_en && low_rd_en) && any_pending)
        else $error("pop from an empty queue");

    // An input transfer always moves the block into the execute cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted item not executed");

endmodule
